@@ rtl/core/rtof_pkg.sv @@
// ----------------------------------------------------------------------------
// rtof_pkg
// Types, codes and sizes shared by the address translation core and its testbench.
// ----------------------------------------------------------------------------
`default_nettype none

package rtof_pkg;

  // section table depth and derived widths
  localparam int unsigned MAX_SECTIONS = 32;
  localparam int unsigned SecIdxW      = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int unsigned SecCountW    = $clog2(MAX_SECTIONS + 1);

  // fixed field widths
  localparam int unsigned DataW     = 32;
  localparam int unsigned EntryIdxW = 5;
  localparam int unsigned SecCfgW   = 6;
  localparam int unsigned CfgIdxW   = 2;

  // item kinds
  localparam logic KindWrite = 1'b0;
  localparam logic KindQuery = 1'b1;

  // result status codes
  localparam logic StatusOk      = 1'b0;
  localparam logic StatusInvalid = 1'b1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgHeaderSize    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgImageFileSize = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSectionsInUse = 2'd2;

  // input transaction
  typedef struct packed {
    logic                 kind;
    logic [EntryIdxW-1:0] entry_index;
    logic [DataW-1:0]     section_base;
    logic [DataW-1:0]     section_span;
    logic [DataW-1:0]     section_raw_length;
    logic [DataW-1:0]     section_raw_start;
    logic [DataW-1:0]     query_address;
    logic [DataW-1:0]     required_bytes;
  } in_t;

  // result transaction
  typedef struct packed {
    logic             status;
    logic [DataW-1:0] file_offset;
    logic [DataW-1:0] available_bytes;
  } out_t;

  // one row of the section table
  typedef struct packed {
    logic [DataW-1:0] virt_addr;
    logic [DataW-1:0] virt_size;
    logic [DataW-1:0] raw_size;
    logic [DataW-1:0] raw_ptr;
  } sec_entry_t;

  localparam int unsigned SecEntryW = $bits(sec_entry_t);

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_SCAN,
    ST_CHK_RAW,
    ST_CHK_FILE,
    ST_FAIL
  } state_e;

endpackage

`default_nettype wire

@@ rtl/core/rva_to_file_offset_core.sv @@
// ----------------------------------------------------------------------------
// rva_to_file_offset_core
// Translates a relative virtual address into a file offset using a section
// table held in RAM, or loads one entry of that table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: a transaction is taken when start_i is high and busy_o is
//   low. Kind write loads item_i's section fields into slot entry_index
//   and gives no result. Kind query gives exactly one result.
//   Results: result_o is valid for the single cycle in which result_valid_o
//   is high; the receiver cannot stall, so there is no back pressure.
//   Configuration: cfg_ready_o is always high; write only while idle.
// Sequence:
//   header query  : header state; result strobe in the cycle busy drops
//   section query : scan state until a row matches, then the raw and file check
//                   states; with no match, or no sections in use, the scan or
//                   fail state ends it; result strobe in the cycle busy drops
//   table write   : busy stays low, next transaction may follow directly
//   The scan reads one table row per cycle from the single read port of the
//   section RAM, which sets the query time.
// Reset: control and configuration registers clear to zero; the datapath
//   registers and the section RAM are not cleared, and a row must be
//   written before any query searches it.
// ----------------------------------------------------------------------------
`default_nettype none

module rva_to_file_offset_core
  import rtof_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // input channel
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire in_t                item_i,
  // result channel
  output logic                    result_valid_o,
  output out_t                    result_o,
  // configuration channel
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [DataW-1:0]   cfg_data_i
);

  localparam int unsigned SlotW  = EntryIdxW + SecIdxW;
  localparam int unsigned ClampW = SecCfgW + SecCountW;

  // configuration registers
  logic [DataW-1:0]   hdr_size_q;
  logic [DataW-1:0]   file_size_q;
  logic [SecCfgW-1:0] sec_used_q;

  // control state
  state_e state_q, state_d;
  logic   result_valid_q, result_valid_d;

  // datapath registers
  logic [DataW-1:0]     rva_q, rva_d;
  logic [DataW-1:0]     req_q, req_d;
  logic [SecCountW-1:0] count_q, count_d;
  logic [SecIdxW-1:0]   idx_q, idx_d;
  logic [DataW-1:0]     raw_q, raw_d;
  logic [DataW-1:0]     ptr_q, ptr_d;
  logic [DataW-1:0]     delta_q, delta_d;
  logic [DataW-1:0]     raw_rem_q, raw_rem_d;
  logic [DataW:0]       roff_q, roff_d;
  logic                 bad_q, bad_d;
  out_t                 result_q, result_d;

  // handshake and RAM controls
  logic               accept;
  logic               ram_we;
  logic [SecIdxW-1:0] ram_waddr;
  sec_entry_t         ram_wdata;
  logic               ram_re;
  logic [SecIdxW-1:0] ram_raddr;
  sec_entry_t         ram_rdata;

  // accept-time decode
  logic [SlotW-1:0]     slot_wide;
  logic [ClampW-1:0]    used_wide;
  logic [SecCountW-1:0] count_clamped;
  logic                 is_query;
  logic                 hdr_hit;

  // scan-time compare
  logic [DataW-1:0] span;
  logic [DataW:0]   sec_end;
  logic             sec_hit;
  logic             scan_last;

  // header path arithmetic
  logic [DataW-1:0] hdr_rem;
  logic [DataW-1:0] hdr_frem;
  logic [DataW-1:0] hdr_avail;

  // file bound arithmetic
  logic [DataW:0]   file_rem;
  logic [DataW-1:0] file_avail;

  assign accept      = start_i && !busy_o;
  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign is_query    = (item_i.kind == KindQuery);

  // slot range check and count clamp
  assign slot_wide     = SlotW'(item_i.entry_index);
  assign used_wide     = ClampW'(sec_used_q);
  assign count_clamped = (used_wide > ClampW'(MAX_SECTIONS)) ?
                         SecCountW'(MAX_SECTIONS) : used_wide[SecCountW-1:0];
  assign hdr_hit       = (item_i.query_address < hdr_size_q);

  // table load: a write is only taken while idle, so it cannot meet a scan read
  assign ram_we    = accept && !is_query && (slot_wide < SlotW'(MAX_SECTIONS));
  assign ram_waddr = slot_wide[SecIdxW-1:0];
  assign ram_wdata = '{virt_addr: item_i.section_base,
                       virt_size: item_i.section_span,
                       raw_size:  item_i.section_raw_length,
                       raw_ptr:   item_i.section_raw_start};

  // span cover test on the row read last cycle
  assign span      = (ram_rdata.raw_size > ram_rdata.virt_size) ?
                     ram_rdata.raw_size : ram_rdata.virt_size;
  assign sec_end   = {1'b0, ram_rdata.virt_addr} + {1'b0, span};
  assign sec_hit   = (rva_q >= ram_rdata.virt_addr) && ({1'b0, rva_q} < sec_end);
  assign scan_last = ((SecCountW'(idx_q) + SecCountW'(1)) == count_q);

  // header region bounds
  assign hdr_rem   = hdr_size_q - rva_q;
  assign hdr_frem  = file_size_q - rva_q;
  assign hdr_avail = (hdr_rem < hdr_frem) ? hdr_rem : hdr_frem;

  // file bounds after the raw data check
  assign file_rem   = {1'b0, file_size_q} - roff_q;
  assign file_avail = (file_rem[DataW-1:0] < raw_rem_q) ? file_rem[DataW-1:0] : raw_rem_q;

  // section table
  rtof_ram #(
    .Width (SecEntryW),
    .Depth (MAX_SECTIONS)
  ) u_sec_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && is_query) begin
          priority if (hdr_hit) begin
            state_d = ST_HDR;
          end else if (count_clamped == '0) begin
            state_d = ST_FAIL;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        priority if (sec_hit) begin
          state_d = ST_CHK_RAW;
        end else if (scan_last) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_CHK_RAW:  state_d = ST_CHK_FILE;
      ST_HDR,
      ST_CHK_FILE,
      ST_FAIL:     state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    rva_d          = rva_q;
    req_d          = req_q;
    count_d        = count_q;
    idx_d          = idx_q;
    raw_d          = raw_q;
    ptr_d          = ptr_q;
    delta_d        = delta_q;
    raw_rem_d      = raw_rem_q;
    roff_d         = roff_q;
    bad_d          = bad_q;
    result_d       = result_q;
    result_valid_d = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = SecIdxW'(idx_q + SecIdxW'(1));

    unique case (state_q)
      ST_IDLE: begin
        // latch the query and fetch row zero
        if (accept && is_query) begin
          rva_d     = item_i.query_address;
          req_d     = item_i.required_bytes;
          count_d   = count_clamped;
          idx_d     = '0;
          ram_re    = 1'b1;
          ram_raddr = '0;
        end
      end
      ST_HDR: begin
        result_valid_d = 1'b1;
        if ((rva_q >= file_size_q) || (req_q > hdr_avail)) begin
          result_d = '{status: StatusInvalid, file_offset: '0, available_bytes: '0};
        end else begin
          result_d = '{status: StatusOk, file_offset: rva_q, available_bytes: hdr_avail};
        end
      end
      ST_SCAN: begin
        // first covering row wins, otherwise fetch the next one or end on the last
        priority if (sec_hit) begin
          raw_d   = ram_rdata.raw_size;
          ptr_d   = ram_rdata.raw_ptr;
          delta_d = rva_q - ram_rdata.virt_addr;
        end else if (scan_last) begin
          result_valid_d = 1'b1;
          result_d = '{status: StatusInvalid, file_offset: '0, available_bytes: '0};
        end else begin
          idx_d  = SecIdxW'(idx_q + SecIdxW'(1));
          ram_re = 1'b1;
        end
      end
      ST_CHK_RAW: begin
        raw_rem_d = raw_q - delta_q;
        bad_d     = (delta_q > raw_q) || (req_q > (raw_q - delta_q));
        roff_d    = {1'b0, ptr_q} + {1'b0, delta_q};
      end
      ST_CHK_FILE: begin
        result_valid_d = 1'b1;
        if (bad_q || (roff_q > {1'b0, file_size_q}) || (req_q > file_avail)) begin
          result_d = '{status: StatusInvalid, file_offset: '0, available_bytes: '0};
        end else begin
          result_d = '{status: StatusOk, file_offset: roff_q[DataW-1:0],
                       available_bytes: file_avail};
        end
      end
      ST_FAIL: begin
        result_valid_d = 1'b1;
        result_d = '{status: StatusInvalid, file_offset: '0, available_bytes: '0};
      end
      default: begin
        result_valid_d = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_q <= result_valid_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_size_q  <= '0;
      file_size_q <= '0;
      sec_used_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgHeaderSize:    hdr_size_q  <= cfg_data_i;
        CfgImageFileSize: file_size_q <= cfg_data_i;
        CfgSectionsInUse: sec_used_q  <= cfg_data_i[SecCfgW-1:0];
        default:          sec_used_q  <= sec_used_q;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rva_q     <= rva_d;
    req_q     <= req_d;
    count_q   <= count_d;
    idx_q     <= idx_d;
    raw_q     <= raw_d;
    ptr_q     <= ptr_d;
    delta_q   <= delta_d;
    raw_rem_q <= raw_rem_d;
    roff_q    <= roff_d;
    bad_q     <= bad_d;
    result_q  <= result_d;
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  // a result only follows a cycle of query work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_q |-> ($past(state_q) != ST_IDLE))
    else $error("result strobe without a query in progress");

  // an invalid result carries zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_q && (result_q.status == StatusInvalid)) |->
      ((result_q.file_offset == '0) && (result_q.available_bytes == '0)))
    else $error("invalid result with non-zero fields");

  // a successful result covers the requested length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_q && (result_q.status == StatusOk)) |->
      (req_q <= result_q.available_bytes))
    else $error("success with fewer bytes than required");

  // the scan stays inside the searched rows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (SecCountW'(idx_q) < count_q))
    else $error("scan index beyond section count");

  // table writes never overlap a query
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ((state_q == ST_IDLE) && !ram_re))
    else $error("table write during a query");

endmodule

`default_nettype wire

@@ rtl/core/rtof_ram.sv @@
// ----------------------------------------------------------------------------
// rtof_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rtof_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                        wdata_i,
  input  wire logic                                    re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rva_to_file_offset_core. Section table loads and
// address queries are fed from a queue, with random gaps, to the command
// port. An internal predictor keeps its own section table and registers,
// works out the result of every accepted query, and the monitor compares
// each result strobe field by field with the oldest prediction. A directed
// opening covers header mapping, empty spans, overlapping sections and
// extreme values. Random phases then load plausible section layouts and
// query them under a range of register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import rtof_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned PHASES      = 12;
  localparam int unsigned PHASE_ITEMS = 130;
  // register index with no register behind it
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               start_i     = 1'b0;
  logic               busy_o;
  in_t                item_i      = '0;
  logic               result_valid_o;
  out_t               result_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [DataW-1:0]   cfg_data_i  = '0;

  // commands waiting for the driver and translations waiting for the monitor
  in_t         pending_commands [$];
  out_t        expected_translations [$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          no_gaps     = 1'b0;

  // predictor copy of the registers and the section table
  logic [DataW-1:0]   hdr_cfg      = '0;
  logic [DataW-1:0]   fsize_cfg    = '0;
  logic [SecCfgW-1:0] sections_cfg = '0;
  sec_entry_t         section_rows [MAX_SECTIONS];

  // layout planned for the current random phase
  logic [DataW-1:0] plan_va  [MAX_SECTIONS];
  logic [DataW-1:0] plan_vs  [MAX_SECTIONS];
  logic [DataW-1:0] plan_raw [MAX_SECTIONS];
  logic [DataW-1:0] plan_ptr [MAX_SECTIONS];
  logic [DataW-1:0] plan_file_end;

  rva_to_file_offset_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // expected translation of one query, sums kept one bit wider
  function automatic out_t translate_rva(logic [DataW-1:0] rva_in, logic [DataW-1:0] req_in);
    logic [DataW:0] rva, req, hdr, fsz, base, raw, span, delta, roff, avail;
    out_t res;
    bit ok, hit;
    int count, i;
    rva   = {1'b0, rva_in};
    req   = {1'b0, req_in};
    hdr   = {1'b0, hdr_cfg};
    fsz   = {1'b0, fsize_cfg};
    ok    = 1'b0;
    hit   = 1'b0;
    roff  = '0;
    avail = '0;
    if (rva < hdr) begin
      // header region maps to itself
      if (rva < fsz) begin
        avail = fsz - rva;
        if (hdr - rva < avail) avail = hdr - rva;
        roff = rva;
        ok   = (req <= avail);
      end
    end else begin
      count = (sections_cfg > MAX_SECTIONS) ? MAX_SECTIONS : int'(sections_cfg);
      // first covering section decides, valid or not
      for (i = 0; i < count && !hit; i++) begin
        base = {1'b0, section_rows[i].virt_addr};
        raw  = {1'b0, section_rows[i].raw_size};
        span = {1'b0, section_rows[i].virt_size};
        if (raw > span) span = raw;
        if (rva >= base && rva < base + span) begin
          hit   = 1'b1;
          delta = rva - base;
          if (delta <= raw && req <= raw - delta) begin
            roff = {1'b0, section_rows[i].raw_ptr} + delta;
            if (roff <= fsz) begin
              avail = raw - delta;
              if (avail > fsz - roff) avail = fsz - roff;
              ok = (req <= avail);
            end
          end
        end
      end
    end
    res.status          = ok ? StatusOk : StatusInvalid;
    res.file_offset     = ok ? roff[DataW-1:0] : '0;
    res.available_bytes = ok ? avail[DataW-1:0] : '0;
    return res;
  endfunction

  function automatic in_t mk_load(logic [EntryIdxW-1:0] slot, logic [DataW-1:0] va,
                                  logic [DataW-1:0] vs, logic [DataW-1:0] raw,
                                  logic [DataW-1:0] ptr);
    in_t c;
    c.kind               = KindWrite;
    c.entry_index        = slot;
    c.section_base       = va;
    c.section_span       = vs;
    c.section_raw_length = raw;
    c.section_raw_start  = ptr;
    c.query_address      = $urandom;
    c.required_bytes     = $urandom;
    return c;
  endfunction

  function automatic in_t mk_query(logic [DataW-1:0] rva, logic [DataW-1:0] req);
    in_t c;
    c.kind               = KindQuery;
    c.entry_index        = EntryIdxW'($urandom_range(0, 31));
    c.section_base       = $urandom;
    c.section_span       = $urandom;
    c.section_raw_length = $urandom;
    c.section_raw_start  = $urandom;
    c.query_address      = rva;
    c.required_bytes     = req;
    return c;
  endfunction

  // byte count around the room that is left, to hit both sides of the bound
  function automatic logic [DataW-1:0] pick_req(logic [DataW-1:0] room);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return room;
      2:       return room + 1;
      3:       return room - 1;
      4:       return $urandom_range(0, 64);
      default: return $urandom;
    endcase
  endfunction

  // one register write on the configuration channel
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgHeaderSize:    hdr_cfg      = val;
      CfgImageFileSize: fsize_cfg    = val;
      CfgSectionsInUse: sections_cfg = val[SecCfgW-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  // wait until the block is idle with nothing outstanding
  task automatic settle(input int unsigned tail);
    while (pending_commands.size() != 0 || start_i || busy_o ||
           expected_translations.size() != 0)
      @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  // plausible image layout, mostly packed sections with the odd wild entry
  task automatic plan_image(input int n);
    logic [DataW-1:0] va_cur, ptr_cur, span;
    int k;
    va_cur  = 32'h1000 * $urandom_range(1, 4);
    ptr_cur = 32'h400;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        plan_va[k]  = $urandom;
        plan_vs[k]  = $urandom;
        plan_raw[k] = $urandom;
        plan_ptr[k] = $urandom;
      end else begin
        plan_vs[k]  = ($urandom_range(0, 7) == 0) ? '0 : $urandom_range(1, 32'h3000);
        plan_raw[k] = 32'h200 * $urandom_range(0, 24);
        plan_va[k]  = va_cur;
        plan_ptr[k] = ptr_cur;
        ptr_cur     = ptr_cur + plan_raw[k];
        span        = (plan_vs[k] > plan_raw[k]) ? plan_vs[k] : plan_raw[k];
        va_cur      = va_cur + ((span + 32'hFFF) & ~32'hFFF);
        // now and then an overlap or a hole
        case ($urandom_range(0, 5))
          0:       va_cur = va_cur - 32'h800;
          1:       va_cur = va_cur + 32'h1000;
          default: ;
        endcase
      end
    end
    plan_file_end = ptr_cur;
  endtask

  // driver: hold a command until taken, otherwise maybe leave a gap
  always @(posedge clk_i) begin : drive_commands
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        pending_commands.delete(0);
        if (item_i.kind == KindWrite) begin
          if (item_i.entry_index < MAX_SECTIONS)
            section_rows[item_i.entry_index] = '{item_i.section_base, item_i.section_span,
                                                 item_i.section_raw_length,
                                                 item_i.section_raw_start};
        end else begin
          expected_translations.push_back(translate_rva(item_i.query_address,
                                                        item_i.required_bytes));
        end
      end
      if (start_i && busy_o) begin
        // transaction still waiting to be taken
      end else if (pending_commands.size() != 0 &&
                   (no_gaps || $urandom_range(0, 99) >= 22)) begin
        start_i <= 1'b1;
        item_i  <= pending_commands[0];
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor: compare every result strobe with the oldest prediction
  always @(posedge clk_i) begin : check_results
    out_t want;
    if (rst_ni && result_valid_o === 1'b1) begin
      if (expected_translations.size() == 0) begin
        error_count++;
        if (error_count <= 100)
          $display("%0t: unexpected result status=%0b offset=%h avail=%h", $time,
                   result_o.status, result_o.file_offset, result_o.available_bytes);
      end else begin
        want = expected_translations.pop_front();
        if (result_o.status !== want.status || result_o.file_offset !== want.file_offset ||
            result_o.available_bytes !== want.available_bytes) begin
          error_count++;
          if (error_count <= 100)
            $display("%0t: mismatch expected status=%0b offset=%h avail=%h, got %0b %h %h",
                     $time, want.status, want.file_offset, want.available_bytes,
                     result_o.status, result_o.file_offset, result_o.available_bytes);
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("rva_to_file_offset_core verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int phase, n, k, r;
    logic [DataW-1:0] hdr, fsz, cnt, rva, off, span, room;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: header mapping, no sections, then load five slots
    write_reg(CfgHeaderSize, 32'h1000);
    write_reg(CfgImageFileSize, 32'h8000);
    write_reg(CfgSectionsInUse, '0);
    write_reg(CfgSpare, $urandom);
    @(negedge clk_i);
    pending_commands.push_back(mk_query(32'h0, 32'h0));
    pending_commands.push_back(mk_query(32'hFFF, 32'h1));
    pending_commands.push_back(mk_query(32'h800, 32'h801));
    pending_commands.push_back(mk_query(32'h1000, 32'h0));
    pending_commands.push_back(mk_load(5'd0, 32'h1000, 32'h2000, 32'h1000, 32'h1000));
    // empty span never matches
    pending_commands.push_back(mk_load(5'd1, 32'h3000, 32'h0, 32'h0, 32'hFFFF_FFFF));
    // overlaps slot 0, which wins even when its answer is invalid
    pending_commands.push_back(mk_load(5'd2, 32'h2800, 32'h100, 32'h800, 32'h4000));
    pending_commands.push_back(mk_load(5'd31, 32'hFFFF_F000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                       32'hFFFF_FFFF));
    pending_commands.push_back(mk_load(5'd3, 32'hFFFF_F000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                       32'hFFFF_FFFF));
    settle(4);

    // directed: section lookups
    write_reg(CfgSectionsInUse, 32'd4);
    @(negedge clk_i);
    pending_commands.push_back(mk_query(32'h1000, 32'h1000));
    pending_commands.push_back(mk_query(32'h1800, 32'h0));
    pending_commands.push_back(mk_query(32'h2800, 32'h10));
    pending_commands.push_back(mk_query(32'h3000, 32'h0));
    pending_commands.push_back(mk_query(32'hFFFF_FFFF, 32'h0));
    pending_commands.push_back(mk_query(32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_commands.push_back(mk_query(32'h0, 32'hFFFF_FFFF));
    settle(4);

    // directed: largest header and file sizes
    write_reg(CfgHeaderSize, 32'hFFFF_FFFF);
    write_reg(CfgImageFileSize, 32'hFFFF_FFFF);
    @(negedge clk_i);
    pending_commands.push_back(mk_query(32'hFFFF_FFFE, 32'h1));
    pending_commands.push_back(mk_query(32'hFFFF_FFFF, 32'h0));
    settle(4);

    // directed: header larger than the file
    write_reg(CfgImageFileSize, 32'h10);
    @(negedge clk_i);
    pending_commands.push_back(mk_query(32'h20, 32'h0));
    pending_commands.push_back(mk_query(32'h8, 32'h8));
    settle(4);

    // random phases, each loading a fresh layout and querying it
    for (phase = 0; phase < PHASES; phase++) begin
      n = (phase == 0) ? MAX_SECTIONS : $urandom_range(1, MAX_SECTIONS);
      plan_image(n);
      case (phase)
        2:       hdr = '0;
        3:       hdr = 32'hFFFF_FFFF;
        default: hdr = ($urandom_range(0, 1) == 0) ? 32'h400 : $urandom_range(0, 32'h2000);
      endcase
      case (phase)
        4:       fsz = '0;
        5:       fsz = 32'hFFFF_FFFF;
        default: fsz = plan_file_end - 32'h400 + $urandom_range(0, 32'h800);
      endcase
      case (phase)
        0:       cnt = MAX_SECTIONS;
        6:       cnt = 32'd63;
        8:       cnt = $urandom_range(33, 62);
        9:       cnt = '0;
        default: cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n) : n;
      endcase
      // the sender holds off here until every translation has come back
      settle(4);
      write_reg(CfgHeaderSize, hdr);
      write_reg(CfgImageFileSize, fsz);
      write_reg(CfgSectionsInUse, cnt);
      no_gaps = (phase == 7);
      @(negedge clk_i);
      for (k = 0; k < n; k++)
        pending_commands.push_back(mk_load(5'(k), plan_va[k], plan_vs[k], plan_raw[k],
                                           plan_ptr[k]));
      for (k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          // address inside or just past a planned section
          n    = (n > 0) ? n : 1;
          r    = $urandom_range(0, n - 1);
          span = (plan_vs[r] > plan_raw[r]) ? plan_vs[r] : plan_raw[r];
          off  = (span > 32'h0010_0000) ? $urandom : $urandom_range(0, span + 8);
          room = (off <= plan_raw[r]) ? plan_raw[r] - off : '0;
          pending_commands.push_back(mk_query(plan_va[r] + off, pick_req(room)));
        end else if (r < 82) begin
          // header region
          rva = (hdr == 0) ? $urandom_range(0, 16) : $urandom_range(0, hdr - 1);
          pending_commands.push_back(mk_query(rva, pick_req(hdr - rva)));
        end else if (r < 92) begin
          pending_commands.push_back(mk_query($urandom, pick_req($urandom)));
        end else begin
          // stray reload of any slot
          pending_commands.push_back(mk_load(EntryIdxW'($urandom_range(0, 31)), $urandom,
                                             $urandom, $urandom, $urandom));
        end
      end
    end

    settle(40);
    if (error_count == 0) begin
      $display("rva_to_file_offset_core verification clean");
    end else begin
      $display("rva_to_file_offset_core verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
rtl/core/rtof_pkg.sv
rtl/core/rtof_ram.sv
rtl/core/rva_to_file_offset_core.sv
dv/testbench.sv
